FILE: rtl/rsh_pkg.sv
// Shared types and constants for the ray/sphere hit test pipeline.
`default_nettype none
package rsh_pkg;

   localparam int SQRT_STEPS = 63;
   localparam int QUO_STEPS  = 31;
   localparam int NRM_STEPS  = 31;

   localparam logic [1:0] CSR_CENTER_X = 2'd0;
   localparam logic [1:0] CSR_CENTER_Y = 2'd1;
   localparam logic [1:0] CSR_CENTER_Z = 2'd2;
   localparam logic [1:0] CSR_RADIUS   = 2'd3;

   typedef struct packed {
      logic [2:0][31:0] org;
      logic [2:0][32:0] dmag;
      logic [2:0]       dneg;
      logic [31:0]      best;
      logic [1:0]       sd;
      logic [1:0]       so;
   } rsh_geo_type;

   typedef struct packed {
      logic        ok;
      logic        h_neg;
      logic [61:0] hm;
      logic [61:0] a;
      rsh_geo_type geo;
   } rsh_ray_type;

   typedef struct packed {
      logic        ok;
      logic [61:0] a;
      rsh_geo_type geo;
   } rsh_quo_type;

   typedef struct packed {
      logic             ok;
      logic [31:0]      t;
      logic [31:0]      best;
      logic [2:0][31:0] pt;
   } rsh_hit_type;

endpackage
`default_nettype wire

FILE: rtl/ray_sphere_hit_test_unit.sv
// Ray/sphere hit test: deep fixed-point pipeline from ray to hit point and normal.
//
// Input channel req_: one ray per transfer (origin, target point and best distance
// so far, all Q16.16). Result channel rsp_: exactly one result per ray, in order:
// updated flag in tuser, new hit parameter (or the best distance passed through),
// hit point and unit normal in tdata (zeros when not updated).
// Configuration csr_: write the sphere centre (indexes 0..2) and radius (index 3)
// while the pipeline is empty.
// Throughput is one ray per cycle while results are taken. The pipeline depth is set
// by the 63-stage square root and the two 31-stage quotient pipelines, plus the
// multiply, add and saturation stages around them.
// The whole pipeline advances together; when the receiver stalls with a result
// waiting, every stage holds and req_tready drops, so nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and sets centre to 0, radius to 1.0.
`default_nettype none
module ray_sphere_hit_test_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, target_x, target_y, target_z, best_distance
   input  wire  [223:0] req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // hit_param, point_x, point_y, point_z, normal_x, normal_y, normal_z
   output logic [223:0] rsp_tdata,
   // updated
   output logic [0:0]   rsp_tuser,
   input  wire          csr_wr_en,
   input  wire  [1:0]   csr_index,
   input  wire  [31:0]  csr_wdata
);

   localparam int QS = rsh_pkg::QUO_STEPS;
   localparam int NS = rsh_pkg::NRM_STEPS;

   logic        adv;
   logic [31:0] cx_ff, cy_ff, cz_ff;
   logic [30:0] rad_ff;
   logic [2:0][31:0] cen;

   assign adv        = ~rsp_tvalid | rsp_tready;
   assign req_tready = adv;
   assign cen        = {cz_ff, cy_ff, cx_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff  <= '0;
         cy_ff  <= '0;
         cz_ff  <= '0;
         rad_ff <= 31'd65536;
      end else if (csr_wr_en) begin
         case (csr_index)
            rsh_pkg::CSR_CENTER_X: cx_ff  <= csr_wdata;
            rsh_pkg::CSR_CENTER_Y: cy_ff  <= csr_wdata;
            rsh_pkg::CSR_CENTER_Z: cz_ff  <= csr_wdata;
            rsh_pkg::CSR_RADIUS:   rad_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // stage 1: input register
   logic             v1_ff;
   logic [2:0][31:0] org1_ff, tgt1_ff;
   logic [31:0]      best1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_tvalid;
      end
      if (adv) begin
         org1_ff  <= req_tdata[95:0];
         tgt1_ff  <= req_tdata[191:96];
         best1_ff <= req_tdata[223:192];
      end
   end

   // stage 2: differences and range reduction
   logic             v2_ff;
   rsh_pkg::rsh_geo_type geo2_in, geo2_ff;
   logic [2:0][30:0] dpm2_in, dpm2_ff, opm2_in, opm2_ff;
   logic [2:0]       dpn2_in, dpn2_ff, opn2_in, opn2_ff;
   logic [30:0]      rp2_in, rp2_ff;

   always_comb begin
      logic [2:0][32:0] dd, oc, ocm;
      logic big1d, big2d, big1o, big2o;
      big1d = 1'b0; big2d = 1'b0;
      big1o = rad_ff[30]; big2o = 1'b0;
      for (int i = 0; i < 3; i++) begin
         dd[i]  = {org1_ff[i][31], org1_ff[i]} - {tgt1_ff[i][31], tgt1_ff[i]};
         oc[i]  = {org1_ff[i][31], org1_ff[i]} - {cen[i][31], cen[i]};
         geo2_in.dmag[i] = dd[i][32] ? 33'(0) - dd[i] : dd[i];
         geo2_in.dneg[i] = dd[i][32];
         ocm[i] = oc[i][32] ? 33'(0) - oc[i] : oc[i];
         opn2_in[i] = oc[i][32];
         big1d = big1d | (geo2_in.dmag[i][32:30] != 3'd0);
         big2d = big2d | (geo2_in.dmag[i][32:31] != 2'd0);
         big1o = big1o | (ocm[i][32:30] != 3'd0);
         big2o = big2o | (ocm[i][32:31] != 2'd0);
      end
      geo2_in.sd   = big2d ? 2'd2 : (big1d ? 2'd1 : 2'd0);
      geo2_in.so   = big2o ? 2'd2 : (big1o ? 2'd1 : 2'd0);
      geo2_in.org  = org1_ff;
      geo2_in.best = best1_ff;
      for (int i = 0; i < 3; i++) begin
         dpm2_in[i] = 31'(geo2_in.dmag[i] >> geo2_in.sd);
         opm2_in[i] = 31'(ocm[i] >> geo2_in.so);
      end
      dpn2_in = geo2_in.dneg;
      rp2_in  = rad_ff >> geo2_in.so;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         geo2_ff <= geo2_in;
         dpm2_ff <= dpm2_in;
         opm2_ff <= opm2_in;
         dpn2_ff <= dpn2_in;
         opn2_ff <= opn2_in;
         rp2_ff  <= rp2_in;
      end
   end

   // stage 3: squares and cross products
   logic             v3_ff;
   rsh_pkg::rsh_geo_type geo3_ff;
   logic [2:0][61:0] dd3_in, dd3_ff, dh3_in, dh3_ff, oo3_in, oo3_ff;
   logic [2:0]       dhn3_in, dhn3_ff;
   logic [61:0]      rr3_in, rr3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd3_in[i]  = dpm2_ff[i] * dpm2_ff[i];
         dh3_in[i]  = dpm2_ff[i] * opm2_ff[i];
         oo3_in[i]  = opm2_ff[i] * opm2_ff[i];
         dhn3_in[i] = dpn2_ff[i] ^ opn2_ff[i];
      end
      rr3_in = rp2_ff * rp2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         geo3_ff <= geo2_ff;
         dd3_ff  <= dd3_in;
         dh3_ff  <= dh3_in;
         oo3_ff  <= oo3_in;
         dhn3_ff <= dhn3_in;
         rr3_ff  <= rr3_in;
      end
   end

   // stage 4: quadratic coefficients
   logic        v4_ff;
   rsh_pkg::rsh_geo_type geo4_ff;
   logic [61:0] a4_in, a4_ff;
   logic [63:0] h4_in, h4_ff, c4_in, c4_ff;

   always_comb begin
      a4_in = dd3_ff[0] + dd3_ff[1] + dd3_ff[2];
      h4_in = '0;
      c4_in = 64'(0) - 64'(rr3_ff);
      for (int i = 0; i < 3; i++) begin
         h4_in = dhn3_ff[i] ? h4_in - 64'(dh3_ff[i]) : h4_in + 64'(dh3_ff[i]);
         c4_in = c4_in + 64'(oo3_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         geo4_ff <= geo3_ff;
         a4_ff   <= a4_in;
         h4_ff   <= h4_in;
         c4_ff   <= c4_in;
      end
   end

   // stage 5: magnitudes
   logic        v5_ff;
   rsh_pkg::rsh_ray_type ray5_in, ray5_ff;
   logic [61:0] cm5_in, cm5_ff;
   logic        cpos5_in, cpos5_ff;

   always_comb begin
      logic [63:0] hn, cn;
      hn = 64'(0) - h4_ff;
      cn = 64'(0) - c4_ff;
      ray5_in.ok    = a4_ff != 62'd0;
      ray5_in.h_neg = h4_ff[63];
      ray5_in.hm    = h4_ff[63] ? hn[61:0] : h4_ff[61:0];
      ray5_in.a     = a4_ff;
      ray5_in.geo   = geo4_ff;
      cm5_in        = c4_ff[63] ? cn[61:0] : c4_ff[61:0];
      cpos5_in      = ~c4_ff[63] & (c4_ff != 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         ray5_ff  <= ray5_in;
         cm5_ff   <= cm5_in;
         cpos5_ff <= cpos5_in;
      end
   end

   // stage 6: partial products of h*h and a*|c|
   logic        v6_ff, cpos6_ff;
   rsh_pkg::rsh_ray_type ray6_ff;
   logic [61:0] hll6_in, hlh6_in, hhh6_in, all6_in, alh6_in, ahl6_in, ahh6_in;
   logic [61:0] hll6_ff, hlh6_ff, hhh6_ff, all6_ff, alh6_ff, ahl6_ff, ahh6_ff;

   always_comb begin
      hll6_in = ray5_ff.hm[30:0]  * ray5_ff.hm[30:0];
      hlh6_in = ray5_ff.hm[30:0]  * ray5_ff.hm[61:31];
      hhh6_in = ray5_ff.hm[61:31] * ray5_ff.hm[61:31];
      all6_in = ray5_ff.a[30:0]   * cm5_ff[30:0];
      alh6_in = ray5_ff.a[30:0]   * cm5_ff[61:31];
      ahl6_in = ray5_ff.a[61:31]  * cm5_ff[30:0];
      ahh6_in = ray5_ff.a[61:31]  * cm5_ff[61:31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         ray6_ff  <= ray5_ff;
         cpos6_ff <= cpos5_ff;
         hll6_ff  <= hll6_in;
         hlh6_ff  <= hlh6_in;
         hhh6_ff  <= hhh6_in;
         all6_ff  <= all6_in;
         alh6_ff  <= alh6_in;
         ahl6_ff  <= ahl6_in;
         ahh6_ff  <= ahh6_in;
      end
   end

   // stage 7: assemble h*h and a*|c|
   logic         v7_ff, cpos7_ff;
   rsh_pkg::rsh_ray_type ray7_ff;
   logic [124:0] h27_in, h27_ff, ac7_in, ac7_ff;

   always_comb begin
      h27_in = (125'(hhh6_ff) << 62) + (125'(hlh6_ff) << 32) + 125'(hll6_ff);
      ac7_in = (125'(ahh6_ff) << 62) + ((125'(alh6_ff) + 125'(ahl6_ff)) << 31)
             + 125'(all6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else if (adv) begin
         v7_ff <= v6_ff;
      end
      if (adv) begin
         ray7_ff  <= ray6_ff;
         cpos7_ff <= cpos6_ff;
         h27_ff   <= h27_in;
         ac7_ff   <= ac7_in;
      end
   end

   // stage 8: discriminant
   logic         v8_ff;
   rsh_pkg::rsh_ray_type ray8_in, ray8_ff;
   logic [124:0] disc8_in, disc8_ff;

   always_comb begin
      ray8_in = ray7_ff;
      if (cpos7_ff) begin
         disc8_in   = h27_ff - ac7_ff;
         ray8_in.ok = ray7_ff.ok & (h27_ff > ac7_ff);
      end else begin
         disc8_in   = h27_ff + ac7_ff;
         ray8_in.ok = ray7_ff.ok & ((h27_ff | ac7_ff) != 125'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else if (adv) begin
         v8_ff <= v7_ff;
      end
      if (adv) begin
         ray8_ff  <= ray8_in;
         disc8_ff <= disc8_in;
      end
   end

   logic        vs;
   logic [62:0] root;
   rsh_pkg::rsh_ray_type rays;

   rsh_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (v8_ff),
      .in_rad   (disc8_ff),
      .in_side  (ray8_ff),
      .out_vld  (vs),
      .out_root (root),
      .out_side (rays)
   );

   // stage M: numerator magnitude
   logic        vm_ff;
   rsh_pkg::rsh_quo_type qm_in, qm_ff;
   logic [63:0] m_in, m_ff;

   always_comb begin
      qm_in.a   = rays.a;
      qm_in.geo = rays.geo;
      qm_in.ok  = rays.ok;
      m_in      = '0;
      if (!rays.h_neg) begin
         m_in = 64'(rays.hm) + 64'(root);
      end else if (63'(rays.hm) < root) begin
         m_in = 64'(root - 63'(rays.hm));
      end else begin
         qm_in.ok = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vm_ff <= 1'b0;
      end else if (adv) begin
         vm_ff <= vs;
      end
      if (adv) begin
         qm_ff <= qm_in;
         m_ff  <= m_in;
      end
   end

   // stage N: scale numerator
   logic        vn_ff;
   rsh_pkg::rsh_quo_type qn_in, qn_ff;
   logic [81:0] num_in, num_ff;

   always_comb begin
      logic [4:0] e;
      e        = 5'd16 + 5'(qm_ff.geo.so) - 5'(qm_ff.geo.sd);
      num_in   = 82'(m_ff) << e;
      qn_in    = qm_ff;
      qn_in.ok = qm_ff.ok & (m_ff != 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vn_ff <= 1'b0;
      end else if (adv) begin
         vn_ff <= vm_ff;
      end
      if (adv) begin
         qn_ff  <= qn_in;
         num_ff <= num_in;
      end
   end

   // stage C: saturation check ahead of the quotient pipeline
   logic        vc_ff, qsat_in, qsat_ff;
   rsh_pkg::rsh_quo_type qc_ff;
   logic [61:0] qrem_in, qrem_ff;
   logic [30:0] qlow_ff;

   always_comb begin
      qsat_in = 62'(num_ff[81:31]) >= qn_ff.a;
      qrem_in = 62'(num_ff[81:31]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else if (adv) begin
         vc_ff <= vn_ff;
      end
      if (adv) begin
         qc_ff   <= qn_ff;
         qsat_ff <= qsat_in;
         qrem_ff <= qrem_in;
         qlow_ff <= num_ff[30:0];
      end
   end

   // quotient pipeline, one bit per stage
   logic [QS-1:0]        qv_ff;
   rsh_pkg::rsh_quo_type qs_ff  [QS];
   logic [61:0]          qr_ff  [QS];
   logic [30:0]          qb_ff  [QS];
   logic [30:0]          ql_ff  [QS];
   logic                 qst_ff [QS];

   for (genvar k = 0; k < QS; k++) begin : g_quo
      logic                 v_cur, st_cur;
      rsh_pkg::rsh_quo_type s_cur;
      logic [61:0]          r_cur, r_in;
      logic [30:0]          b_cur, l_cur, b_in;
      logic [62:0]          trial;

      if (k == 0) begin : g_first
         assign v_cur  = vc_ff;
         assign s_cur  = qc_ff;
         assign r_cur  = qrem_ff;
         assign b_cur  = '0;
         assign l_cur  = qlow_ff;
         assign st_cur = qsat_ff;
      end else begin : g_next
         assign v_cur  = qv_ff[k-1];
         assign s_cur  = qs_ff[k-1];
         assign r_cur  = qr_ff[k-1];
         assign b_cur  = qb_ff[k-1];
         assign l_cur  = ql_ff[k-1];
         assign st_cur = qst_ff[k-1];
      end

      always_comb begin
         trial = {r_cur, l_cur[QS-1-k]};
         b_in  = b_cur;
         if (trial >= {1'b0, s_cur.a}) begin
            r_in            = 62'(trial - {1'b0, s_cur.a});
            b_in[QS-1-k]    = 1'b1;
         end else begin
            r_in = trial[61:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            qv_ff[k] <= 1'b0;
         end else if (adv) begin
            qv_ff[k] <= v_cur;
         end
         if (adv) begin
            qs_ff[k]  <= s_cur;
            qr_ff[k]  <= r_in;
            qb_ff[k]  <= b_in;
            ql_ff[k]  <= l_cur;
            qst_ff[k] <= st_cur;
         end
      end
   end

   // stage Q: hit parameter and acceptance test
   logic        vq_ff;
   rsh_pkg::rsh_quo_type qq_in, qq_ff;
   logic [31:0] q_in, q_ff, t_in, t_ff;

   always_comb begin
      logic [32:0] t33;
      q_in     = qst_ff[QS-1] ? 32'h8000_0000 : {1'b0, qb_ff[QS-1]};
      t33      = 33'(0) - {1'b0, q_in};
      t_in     = t33[31:0];
      qq_in    = qs_ff[QS-1];
      qq_in.ok = qs_ff[QS-1].ok & (q_in != 32'd0)
               & ($signed(t33) > $signed({qq_in.geo.best[31], qq_in.geo.best}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vq_ff <= 1'b0;
      end else if (adv) begin
         vq_ff <= qv_ff[QS-1];
      end
      if (adv) begin
         qq_ff <= qq_in;
         q_ff  <= q_in;
         t_ff  <= t_in;
      end
   end

   // stage P: step along the ray
   logic             vp_ff;
   rsh_pkg::rsh_quo_type qp_ff;
   logic [31:0]      tp_ff;
   logic [2:0][47:0] prod_in, prod_ff;

   always_comb begin
      logic [64:0] p;
      for (int i = 0; i < 3; i++) begin
         p          = q_ff * qq_ff.geo.dmag[i];
         prod_in[i] = p[63:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= vq_ff;
      end
      if (adv) begin
         qp_ff   <= qq_ff;
         tp_ff   <= t_ff;
         prod_ff <= prod_in;
      end
   end

   // stage T: hit point with saturation
   logic        vt_ff;
   rsh_pkg::rsh_hit_type ht_in, ht_ff;

   always_comb begin
      logic [49:0] sum;
      ht_in.ok   = qp_ff.ok;
      ht_in.t    = tp_ff;
      ht_in.best = qp_ff.geo.best;
      for (int i = 0; i < 3; i++) begin
         sum = {{18{qp_ff.geo.org[i][31]}}, qp_ff.geo.org[i]};
         sum = qp_ff.geo.dneg[i] ? sum + 50'(prod_ff[i]) : sum - 50'(prod_ff[i]);
         if (!sum[49] && sum[48:31] != 18'd0) begin
            ht_in.pt[i] = 32'h7FFF_FFFF;
         end else if (sum[49] && sum[48:31] != {18{1'b1}}) begin
            ht_in.pt[i] = 32'h8000_0000;
         end else begin
            ht_in.pt[i] = sum[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vt_ff <= 1'b0;
      end else if (adv) begin
         vt_ff <= vp_ff;
      end
      if (adv) begin
         ht_ff <= ht_in;
      end
   end

   // stage D: offset from centre, saturation check ahead of the normal dividers
   logic             vd_ff;
   rsh_pkg::rsh_hit_type hd_ff;
   logic [2:0]       nneg_in, nneg_ff, nsat_in, nsat_ff;
   logic [2:0][30:0] nrem_in, nrem_ff, nlow_in, nlow_ff;

   always_comb begin
      logic [32:0] diff, dmg;
      for (int i = 0; i < 3; i++) begin
         diff       = {ht_ff.pt[i][31], ht_ff.pt[i]} - {cen[i][31], cen[i]};
         dmg        = diff[32] ? 33'(0) - diff : diff;
         nneg_in[i] = diff[32];
         nsat_in[i] = 31'(dmg[31:15]) >= rad_ff;
         nrem_in[i] = 31'(dmg[31:15]);
         nlow_in[i] = {dmg[14:0], 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else if (adv) begin
         vd_ff <= vt_ff;
      end
      if (adv) begin
         hd_ff   <= ht_ff;
         nneg_ff <= nneg_in;
         nsat_ff <= nsat_in;
         nrem_ff <= nrem_in;
         nlow_ff <= nlow_in;
      end
   end

   // normal dividers, three lanes, one bit per stage
   logic [NS-1:0]        nv_ff;
   rsh_pkg::rsh_hit_type nh_ff [NS];
   logic [2:0][30:0]     nr_ff [NS];
   logic [2:0][30:0]     nb_ff [NS];
   logic [2:0][30:0]     nl_ff [NS];
   logic [2:0]           ns_ff [NS];
   logic [2:0]           nn_ff [NS];

   for (genvar k = 0; k < NS; k++) begin : g_nrm
      logic                 v_cur;
      rsh_pkg::rsh_hit_type h_cur;
      logic [2:0][30:0]     r_cur, b_cur, l_cur, r_in, b_in;
      logic [2:0]           s_cur, n_cur;

      if (k == 0) begin : g_first
         assign v_cur = vd_ff;
         assign h_cur = hd_ff;
         assign r_cur = nrem_ff;
         assign b_cur = '0;
         assign l_cur = nlow_ff;
         assign s_cur = nsat_ff;
         assign n_cur = nneg_ff;
      end else begin : g_next
         assign v_cur = nv_ff[k-1];
         assign h_cur = nh_ff[k-1];
         assign r_cur = nr_ff[k-1];
         assign b_cur = nb_ff[k-1];
         assign l_cur = nl_ff[k-1];
         assign s_cur = ns_ff[k-1];
         assign n_cur = nn_ff[k-1];
      end

      always_comb begin
         logic [31:0] trial;
         b_in = b_cur;
         for (int i = 0; i < 3; i++) begin
            trial = {r_cur[i], l_cur[i][NS-1-k]};
            if (trial >= {1'b0, rad_ff}) begin
               r_in[i]         = 31'(trial - {1'b0, rad_ff});
               b_in[i][NS-1-k] = 1'b1;
            end else begin
               r_in[i] = trial[30:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[k] <= 1'b0;
         end else if (adv) begin
            nv_ff[k] <= v_cur;
         end
         if (adv) begin
            nh_ff[k] <= h_cur;
            nr_ff[k] <= r_in;
            nb_ff[k] <= b_in;
            nl_ff[k] <= l_cur;
            ns_ff[k] <= s_cur;
            nn_ff[k] <= n_cur;
         end
      end
   end

   // output register
   logic             vo_ff;
   logic             upd_in, upd_ff;
   logic [31:0]      hp_in, hp_ff;
   logic [2:0][31:0] po_in, po_ff, no_in, no_ff;

   always_comb begin
      logic [31:0] qv, nv;
      rsh_pkg::rsh_hit_type hf;
      hf     = nh_ff[NS-1];
      upd_in = hf.ok;
      hp_in  = hf.ok ? hf.t : hf.best;
      for (int i = 0; i < 3; i++) begin
         qv = {1'b0, nb_ff[NS-1][i]};
         if (nn_ff[NS-1][i]) begin
            nv = ns_ff[NS-1][i] ? 32'h8000_0000 : 32'(0) - qv;
         end else begin
            nv = ns_ff[NS-1][i] ? 32'h7FFF_FFFF : qv;
         end
         po_in[i] = hf.ok ? hf.pt[i] : 32'd0;
         no_in[i] = hf.ok ? nv : 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else if (adv) begin
         vo_ff <= nv_ff[NS-1];
      end
      if (adv) begin
         upd_ff <= upd_in;
         hp_ff  <= hp_in;
         po_ff  <= po_in;
         no_ff  <= no_in;
      end
   end

   assign rsp_tvalid = vo_ff;
   assign rsp_tdata  = {no_ff, po_ff, hp_ff};
   assign rsp_tuser  = upd_ff;

endmodule
`default_nettype wire

FILE: rtl/rsh_sqrt.sv
// Pipelined floor square root, one result bit per stage, with a payload carried alongside.
`default_nettype none
module rsh_sqrt (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  adv,
   input  wire                  in_vld,
   input  wire  [124:0]         in_rad,
   input  rsh_pkg::rsh_ray_type in_side,
   output logic                 out_vld,
   output logic [62:0]          out_root,
   output rsh_pkg::rsh_ray_type out_side
);

   logic [rsh_pkg::SQRT_STEPS-1:0] vld_ff;
   logic [125:0]                   x_ff   [rsh_pkg::SQRT_STEPS];
   logic [125:0]                   res_ff [rsh_pkg::SQRT_STEPS];
   rsh_pkg::rsh_ray_type           side_ff[rsh_pkg::SQRT_STEPS];

   for (genvar k = 0; k < rsh_pkg::SQRT_STEPS; k++) begin : g_step
      localparam int SHIFT = 2 * (rsh_pkg::SQRT_STEPS - 1 - k);
      logic                 v_cur;
      logic [125:0]         x_cur, res_cur, trial, x_in, res_in;
      rsh_pkg::rsh_ray_type s_cur;

      if (k == 0) begin : g_first
         assign v_cur   = in_vld;
         assign x_cur   = {1'b0, in_rad};
         assign res_cur = '0;
         assign s_cur   = in_side;
      end else begin : g_next
         assign v_cur   = vld_ff[k-1];
         assign x_cur   = x_ff[k-1];
         assign res_cur = res_ff[k-1];
         assign s_cur   = side_ff[k-1];
      end

      always_comb begin
         trial = res_cur + (126'(1) << SHIFT);
         if (x_cur >= trial) begin
            x_in   = x_cur - trial;
            res_in = (res_cur >> 1) + (126'(1) << SHIFT);
         end else begin
            x_in   = x_cur;
            res_in = res_cur >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= v_cur;
         end
         if (adv) begin
            x_ff[k]    <= x_in;
            res_ff[k]  <= res_in;
            side_ff[k] <= s_cur;
         end
      end
   end

   assign out_vld  = vld_ff[rsh_pkg::SQRT_STEPS-1];
   assign out_root = res_ff[rsh_pkg::SQRT_STEPS-1][62:0];
   assign out_side = side_ff[rsh_pkg::SQRT_STEPS-1];

endmodule
`default_nettype wire

FILE: tb/ray_sphere_hit_test_unit_tb.sv
// Self-checking testbench for the ray/sphere hit test pipeline: directed table, random rays.
`default_nettype none
module ray_sphere_hit_test_unit_tb;

   typedef struct {
      logic        updated;
      logic [31:0] hit_param;
      logic [31:0] pt [3];
      logic [31:0] nrm [3];
   } hit_result_type;

   typedef struct {
      logic [31:0] org [3];
      logic [31:0] tgt [3];
      logic [31:0] best;
      logic        known;
      logic        exp_upd;
      logic [31:0] exp_param;
   } ray_row_type;

   localparam int LATENCY = 141;
   localparam int N_RANDOM = 1080;
   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [223:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [223:0] rsp_tdata;
   logic [0:0] rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   longint sph_centre [3];
   longint sph_radius;
   hit_result_type hits_due [$];
   int errors = 0;
   longint cycles = 0;
   bit quiet = 1'b0;
   ray_row_type dir_rows [$];

   ray_sphere_hit_test_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[ray_sphere_hit_test_unit] ERROR");
         $finish;
      end
   end

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint shrink(longint v, int s);
      longint m;
      m = (v < 0 ? -v : v) >>> s;
      return v < 0 ? -m : m;
   endfunction

   function automatic logic [127:0] isqrt(logic [127:0] x);
      logic [127:0] r, c;
      r = '0;
      for (int b = 62; b >= 0; b--) begin
         c = r | (128'd1 << b);
         if (c * c <= x) r = c;
      end
      return r;
   endfunction

   function automatic hit_result_type hit_test(ray_row_type row);
      hit_result_type res;
      longint o [3], d [3], oc [3], dp [3], op [3];
      longint a, h, cc, rp, best, hm, q, tval, prod, diff, dm, ptv;
      logic [127:0] h2, ac, disc, s, m, num;
      int sd, so, e;
      bit big;
      best = longint'($signed(row.best));
      res.updated = 1'b0;
      res.hit_param = row.best;
      for (int i = 0; i < 3; i++) begin
         res.pt[i] = '0;
         res.nrm[i] = '0;
         o[i] = longint'($signed(row.org[i]));
         d[i] = o[i] - longint'($signed(row.tgt[i]));
         oc[i] = o[i] - sph_centre[i];
      end
      sd = 0;
      so = 0;
      for (int k = 0; k < 2; k++) begin
         big = 0;
         for (int i = 0; i < 3; i++)
            if (((d[i] < 0 ? -d[i] : d[i]) >> sd) >= (64'd1 << 30)) big = 1;
         if (big) sd++;
         big = (sph_radius >> so) >= (64'd1 << 30);
         for (int i = 0; i < 3; i++)
            if (((oc[i] < 0 ? -oc[i] : oc[i]) >> so) >= (64'd1 << 30)) big = 1;
         if (big) so++;
      end
      rp = sph_radius >> so;
      cc = -rp * rp;
      a = 0;
      h = 0;
      for (int i = 0; i < 3; i++) begin
         dp[i] = shrink(d[i], sd);
         op[i] = shrink(oc[i], so);
         a += dp[i] * dp[i];
         h += dp[i] * op[i];
         cc += op[i] * op[i];
      end
      if (a <= 0) return res;
      hm = h < 0 ? -h : h;
      h2 = 128'(hm) * 128'(hm);
      ac = 128'(a) * 128'(cc < 0 ? -cc : cc);
      if (cc <= 0) disc = h2 + ac;
      else begin
         if (h2 <= ac) return res;
         disc = h2 - ac;
      end
      if (disc == 0) return res;
      s = isqrt(disc);
      if (h >= 0) m = 128'(h) + s;
      else if (s > 128'(hm)) m = s - 128'(hm);
      else return res;
      if (m == 0) return res;
      e = 16 + so - sd;
      num = m << e;
      num = num / 128'(a);
      q = (num > (128'd1 << 31)) ? (64'sd1 <<< 31) : longint'(num);
      if (q == 0) return res;
      tval = -q;
      if (!(tval > best)) return res;
      for (int i = 0; i < 3; i++) begin
         prod = longint'((128'(q) * 128'(d[i] < 0 ? -d[i] : d[i])) >> 16);
         ptv = sat32(o[i] + (d[i] < 0 ? prod : -prod));
         res.pt[i] = ptv[31:0];
         if (sph_radius != 0) begin
            diff = ptv - sph_centre[i];
            dm = ((diff < 0 ? -diff : diff) <<< 16) / sph_radius;
            if (dm > (64'sd1 <<< 32)) dm = 64'sd1 <<< 32;
            dm = sat32(diff < 0 ? -dm : dm);
            res.nrm[i] = dm[31:0];
         end
      end
      res.updated = 1'b1;
      res.hit_param = tval[31:0];
      return res;
   endfunction

   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         rsh_pkg::CSR_CENTER_X: sph_centre[0] = longint'($signed(val));
         rsh_pkg::CSR_CENTER_Y: sph_centre[1] = longint'($signed(val));
         rsh_pkg::CSR_CENTER_Z: sph_centre[2] = longint'($signed(val));
         rsh_pkg::CSR_RADIUS:   sph_radius = longint'(val[30:0]);
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (hits_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic send_ray(ray_row_type row);
      hit_result_type res;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {row.best, row.tgt[2], row.tgt[1], row.tgt[0],
                    row.org[2], row.org[1], row.org[0]};
      res = hit_test(row);
      if (row.known && (res.updated !== row.exp_upd || res.hit_param !== row.exp_param)) begin
         $display("%0t table row disagrees: expected %0b/%h, predicted %0b/%h", $time,
                  row.exp_upd, row.exp_param, res.updated, res.hit_param);
         errors++;
      end
      if (row.known) begin
         res.updated = row.exp_upd;
         res.hit_param = row.exp_param;
      end
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hits_due.push_back(res);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'h8000_0000;
         2: return 32'h7fff_ffff;
         default: return $urandom_range(0, 32'h000c_0000) - 32'h0006_0000;
      endcase
   endfunction

   function automatic ray_row_type mk_row(logic [31:0] ox, oy, oz, tx, ty, tz, bd);
      ray_row_type r;
      r.org = '{ox, oy, oz};
      r.tgt = '{tx, ty, tz};
      r.best = bd;
      r.known = 1'b0;
      r.exp_upd = 1'b0;
      r.exp_param = bd;
      return r;
   endfunction

   // random ray aimed mostly at the sphere, with a target beyond the origin
   function automatic ray_row_type rand_ray();
      ray_row_type r;
      longint span;
      span = sph_radius * 4 + 1;
      if ($urandom_range(0, 4) == 0) begin
         r = mk_row(rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord(), $urandom());
      end else begin
         for (int i = 0; i < 3; i++) begin
            r.tgt[i] = 32'(sat32(sph_centre[i] + longint'($urandom_range(0, 32'(span)))
                                 - span / 2));
            r.org[i] = 32'(sat32(longint'($signed(r.tgt[i]))
                                 + longint'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000));
         end
         r.best = $urandom_range(0, 3) == 0 ? $urandom() : 32'h8000_0000;
         r.known = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      hit_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hits_due.size() == 0) begin
            $display("%0t unexpected result %h/%h", $time, rsp_tuser, rsp_tdata);
            errors++;
         end else begin
            want = hits_due.pop_front();
            if (rsp_tuser[0] !== want.updated
                || rsp_tdata !== {want.nrm[2], want.nrm[1], want.nrm[0],
                                  want.pt[2], want.pt[1], want.pt[0], want.hit_param}) begin
               $display("%0t mismatch: expected %b/%h actual %b/%h", $time, want.updated,
                        {want.nrm[2], want.nrm[1], want.nrm[0], want.pt[2], want.pt[1],
                         want.pt[0], want.hit_param}, rsp_tuser, rsp_tdata);
               errors++;
            end
         end
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      ray_row_type r;
      sph_centre = '{0, 0, 0};
      sph_radius = 65536;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // unit sphere at origin, ray along -z from z=2 towards z=1
      dir_rows.push_back(mk_row(0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'h8000_0000));
      dir_rows.push_back(mk_row(0, 0, 32'h0002_0000, 0, 0, 32'h0001_0000, 32'hffff_0000));
      dir_rows.push_back(mk_row(0, 0, 32'h0002_0000, 0, 0, 32'h0003_0000, 32'h8000_0000));
      dir_rows.push_back(mk_row(0, 32'h0005_0000, 32'h0002_0000, 0, 32'h0005_0000,
                                32'h0001_0000, 32'h8000_0000));
      dir_rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
      dir_rows.push_back(mk_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
      dir_rows.push_back(mk_row(32'h0000_4000, 32'h0000_8000, 32'h0000_2000,
                                32'hffff_0000, 32'h0000_1000, 32'h0003_0000, 32'h8000_0000));
      dir_rows.push_back(mk_row(0, 0, 0, 0, 0, 32'h0001_0000, 32'h8000_0000));
      // zero direction: no update, best passes through
      r = mk_row(32'h1234_5678, 1, 2, 32'h1234_5678, 1, 2, 32'hdead_beef);
      r.known = 1'b1;
      dir_rows.push_back(r);
      r = mk_row(0, 0, 32'h0010_0000, 0, 32'h0010_0000, 32'h0010_0000, 32'h7fff_ffff);
      r.known = 1'b1;
      dir_rows.push_back(r);
      foreach (dir_rows[i]) send_ray(dir_rows[i]);
      drain();

      // extreme sphere settings
      write_csr(rsh_pkg::CSR_RADIUS, 32'h7fff_ffff);
      write_csr(rsh_pkg::CSR_CENTER_X, 32'h8000_0000);
      write_csr(rsh_pkg::CSR_CENTER_Y, 32'h7fff_ffff);
      write_csr(rsh_pkg::CSR_CENTER_Z, 32'h0000_0000);
      foreach (dir_rows[i]) send_ray(dir_rows[i]);
      for (int k = 0; k < 60; k++) send_ray(rand_ray());
      drain();
      write_csr(rsh_pkg::CSR_RADIUS, 32'h0000_0001);
      write_csr(rsh_pkg::CSR_CENTER_X, 32'h7fff_ffff);
      for (int k = 0; k < 60; k++) send_ray(rand_ray());
      drain();
      write_csr(rsh_pkg::CSR_RADIUS, 32'h8000_0000);
      for (int k = 0; k < 30; k++) send_ray(rand_ray());
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_csr(rsh_pkg::CSR_CENTER_X, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
         write_csr(rsh_pkg::CSR_CENTER_Y, ph == 2 ? $urandom() :
                   $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
         write_csr(rsh_pkg::CSR_CENTER_Z, $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
         write_csr(rsh_pkg::CSR_RADIUS, ph == 3 ? $urandom() :
                   $urandom_range(32'h0000_4000, 32'h0004_0000));
         if (ph == 5) quiet = 1'b1;
         for (int k = 0; k < N_RANDOM / 6; k++) send_ray(rand_ray());
         drain();
      end

      if (errors == 0) begin
         $display("[ray_sphere_hit_test_unit] OK");
      end else begin
         $display("[ray_sphere_hit_test_unit] ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
